// ===== design/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// No dependencies; used by ffha_mem, ffha_walker and first_fit_heap_allocator.
`default_nettype none

package ffha_pkg;

  localparam int GRAN_W        = 10;              // granule index width
  localparam int HEAP_GRANULES = 1 << GRAN_W;
  localparam int SIZE_W        = 11;              // header size field, in granules
  localparam int BYTES_W       = 13;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;

  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COAL  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              alloc;
  } header_t;

  typedef struct packed {
    logic              en;
    logic [GRAN_W-1:0] addr;
    header_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [GRAN_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic                valid;
    logic [GRAN_W-1:0]   payload;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Granules for a request: its bytes plus a four-byte header, rounded up to whole granules.
  function automatic logic [SIZE_W-1:0] granules_for(input logic [BYTES_W-1:0] bytes);
    logic [BYTES_W:0] sum;
    sum = {1'b0, bytes} + (BYTES_W+1)'(3);
    return SIZE_W'(sum >> 3) + SIZE_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== design/ffha_mem.sv =====
// Header store: one write port, one read port, registered read data.
// Depends on ffha_pkg for widths and the header/port structs.
`default_nettype none

module ffha_mem (
  input  wire logic              clk,
  input  wire ffha_pkg::mem_wr_t wr,
  input  wire ffha_pkg::mem_rd_t rd,
  output ffha_pkg::header_t      rd_data
);

  ffha_pkg::header_t mem [ffha_pkg::HEAP_GRANULES];
  ffha_pkg::header_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/ffha_walker.sv =====
// Control sequencer: walks the block headers in the header store for init,
// allocate, free and coalesce. Depends on ffha_pkg; drives ffha_mem ports.
`default_nettype none

module ffha_walker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ffha_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [ffha_pkg::BYTES_W-1:0]  in_request_bytes,
  input  wire logic [ffha_pkg::GRAN_W-1:0]   in_block_granule,
  output ffha_pkg::mem_wr_t                  mem_wr,
  output ffha_pkg::mem_rd_t                  mem_rd,
  input  wire ffha_pkg::header_t             mem_rd_data,
  output ffha_pkg::result_t                  res,
  input  wire logic                          res_ready
);

  typedef enum logic [3:0] {
    ST_BOOT_HDR,
    ST_BOOT_SENT,
    ST_IDLE,
    ST_INIT,
    ST_INIT_SENT,
    ST_F_LD,
    ST_F_CHK,
    ST_F_SPLIT,
    ST_M_LD,
    ST_M_CHK,
    ST_M_NXT,
    ST_R_LD,
    ST_R_CHK,
    ST_FIN
  } state_t;

  state_t                             state_r, state_nxt;
  logic [ffha_pkg::MODE_W-1:0]        mode_r, mode_nxt;
  logic [ffha_pkg::SIZE_W-1:0]        need_r, need_nxt;
  logic [ffha_pkg::GRAN_W-1:0]        target_r, target_nxt;
  logic [ffha_pkg::GRAN_W-1:0]        g_r, g_nxt;
  logic [ffha_pkg::GRAN_W-1:0]        n_r, n_nxt;
  ffha_pkg::header_t                  h_r, h_nxt;
  logic [ffha_pkg::GRAN_W-1:0]        heap_end_r, heap_end_nxt;
  logic                               retried_r, retried_nxt;
  logic [ffha_pkg::GRAN_W-1:0]        res_payload_r, res_payload_nxt;
  logic [ffha_pkg::STATUS_W-1:0]      res_status_r, res_status_nxt;

  logic [ffha_pkg::SIZE_W-1:0] sz;
  logic [ffha_pkg::SIZE_W-1:0] remain;
  logic [ffha_pkg::SIZE_W-1:0] nsum;
  logic [ffha_pkg::SIZE_W-1:0] n_remain;
  logic [ffha_pkg::SIZE_W-1:0] msum;
  logic                        bad;
  logic                        n_last;
  logic                        n_bad;
  logic [ffha_pkg::GRAN_W-1:0] nxt_g;

  always_comb begin
    sz       = h_r.size;
    remain   = {1'b0, heap_end_r} - {1'b0, g_r};
    bad      = (sz == '0) || (sz > remain);
    nsum     = {1'b0, g_r} + sz;
    n_last   = nsum >= {1'b0, heap_end_r};
    nxt_g    = nsum[ffha_pkg::GRAN_W-1:0];
    n_remain = {1'b0, heap_end_r} - {1'b0, n_r};
    n_bad    = (mem_rd_data.size == '0) || (mem_rd_data.size > n_remain);
    msum     = sz + mem_rd_data.size;
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    need_nxt        = need_r;
    target_nxt      = target_r;
    g_nxt           = g_r;
    n_nxt           = n_r;
    h_nxt           = h_r;
    heap_end_nxt    = heap_end_r;
    retried_nxt     = retried_r;
    res_payload_nxt = res_payload_r;
    res_status_nxt  = res_status_r;
    mem_wr          = '0;
    mem_rd.en       = 1'b0;
    mem_rd.addr     = '0;

    unique case (state_r)
      ST_BOOT_HDR: begin
        mem_wr.en         = 1'b1;
        mem_wr.addr       = '0;
        mem_wr.data.size  = ffha_pkg::SIZE_W'(ffha_pkg::HEAP_GRANULES - 1);
        mem_wr.data.alloc = 1'b0;
        state_nxt         = ST_BOOT_SENT;
      end
      ST_BOOT_SENT: begin
        mem_wr.en         = 1'b1;
        mem_wr.addr       = ffha_pkg::GRAN_W'(ffha_pkg::HEAP_GRANULES - 1);
        mem_wr.data.size  = '0;
        mem_wr.data.alloc = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt    = in_mode;
          need_nxt    = ffha_pkg::granules_for(in_request_bytes);
          target_nxt  = in_block_granule;
          retried_nxt = 1'b0;
          g_nxt       = '0;
          mem_rd.en   = (in_mode != ffha_pkg::MODE_INIT);
          unique case (in_mode)
            ffha_pkg::MODE_INIT:  state_nxt = ST_INIT;
            ffha_pkg::MODE_ALLOC: state_nxt = ST_F_LD;
            ffha_pkg::MODE_FREE:  state_nxt = ST_R_LD;
            ffha_pkg::MODE_COAL:  state_nxt = ST_M_LD;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INIT: begin
        if (need_r > ffha_pkg::SIZE_W'(ffha_pkg::HEAP_GRANULES - 1)) begin
          res_payload_nxt = '0;
          res_status_nxt  = ffha_pkg::STATUS_NO_SPACE;
          state_nxt       = ST_FIN;
        end else begin
          mem_wr.en         = 1'b1;
          mem_wr.addr       = '0;
          mem_wr.data.size  = need_r;
          mem_wr.data.alloc = 1'b0;
          state_nxt         = ST_INIT_SENT;
        end
      end
      ST_INIT_SENT: begin
        mem_wr.en         = 1'b1;
        mem_wr.addr       = need_r[ffha_pkg::GRAN_W-1:0];
        mem_wr.data.size  = '0;
        mem_wr.data.alloc = 1'b1;
        heap_end_nxt      = need_r[ffha_pkg::GRAN_W-1:0];
        res_payload_nxt   = '0;
        res_status_nxt    = ffha_pkg::STATUS_OK;
        state_nxt         = ST_FIN;
      end
      ST_F_LD: begin
        h_nxt     = mem_rd_data;
        state_nxt = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (!bad && !h_r.alloc && sz > need_r) begin
          mem_wr.en         = 1'b1;
          mem_wr.addr       = g_r;
          mem_wr.data.size  = need_r;
          mem_wr.data.alloc = 1'b1;
          state_nxt         = ST_F_SPLIT;
        end else if (!bad && !h_r.alloc && sz == need_r) begin
          mem_wr.en         = 1'b1;
          mem_wr.addr       = g_r;
          mem_wr.data.size  = sz;
          mem_wr.data.alloc = 1'b1;
          res_payload_nxt   = g_r;
          res_status_nxt    = ffha_pkg::STATUS_OK;
          state_nxt         = ST_FIN;
        end else if (bad || n_last) begin
          // no fit on this pass: merge and retry once
          if (retried_r) begin
            res_payload_nxt = '0;
            res_status_nxt  = ffha_pkg::STATUS_NO_SPACE;
            state_nxt       = ST_FIN;
          end else begin
            retried_nxt = 1'b1;
            g_nxt       = '0;
            mem_rd.en   = 1'b1;
            state_nxt   = ST_M_LD;
          end
        end else begin
          g_nxt       = nxt_g;
          mem_rd.en   = 1'b1;
          mem_rd.addr = nxt_g;
          state_nxt   = ST_F_LD;
        end
      end
      ST_F_SPLIT: begin
        // remainder of the split becomes a free block
        mem_wr.en         = 1'b1;
        mem_wr.addr       = g_r + need_r[ffha_pkg::GRAN_W-1:0];
        mem_wr.data.size  = sz - need_r;
        mem_wr.data.alloc = 1'b0;
        res_payload_nxt   = g_r;
        res_status_nxt    = ffha_pkg::STATUS_OK;
        state_nxt         = ST_FIN;
      end
      ST_M_LD: begin
        h_nxt     = mem_rd_data;
        state_nxt = ST_M_CHK;
      end
      ST_M_CHK: begin
        if (bad || n_last) begin
          if (mode_r == ffha_pkg::MODE_COAL) begin
            res_payload_nxt = '0;
            res_status_nxt  = ffha_pkg::STATUS_OK;
            state_nxt       = ST_FIN;
          end else begin
            g_nxt     = '0;
            mem_rd.en = 1'b1;
            state_nxt = ST_F_LD;
          end
        end else begin
          n_nxt       = nxt_g;
          mem_rd.en   = 1'b1;
          mem_rd.addr = nxt_g;
          if (h_r.alloc) begin
            g_nxt     = nxt_g;
            state_nxt = ST_M_LD;
          end else begin
            state_nxt = ST_M_NXT;
          end
        end
      end
      ST_M_NXT: begin
        if (mem_rd_data.alloc) begin
          g_nxt     = n_r;
          h_nxt     = mem_rd_data;
          state_nxt = ST_M_CHK;
        end else if (n_bad) begin
          if (mode_r == ffha_pkg::MODE_COAL) begin
            res_payload_nxt = '0;
            res_status_nxt  = ffha_pkg::STATUS_OK;
            state_nxt       = ST_FIN;
          end else begin
            g_nxt     = '0;
            mem_rd.en = 1'b1;
            state_nxt = ST_F_LD;
          end
        end else begin
          // absorb the free neighbor; g stays put and is checked again
          mem_wr.en         = 1'b1;
          mem_wr.addr       = g_r;
          mem_wr.data.size  = msum;
          mem_wr.data.alloc = 1'b0;
          h_nxt.size        = msum;
          h_nxt.alloc       = 1'b0;
          state_nxt         = ST_M_CHK;
        end
      end
      ST_R_LD: begin
        h_nxt     = mem_rd_data;
        state_nxt = ST_R_CHK;
      end
      ST_R_CHK: begin
        res_payload_nxt = '0;
        if (g_r == target_r) begin
          if (h_r.alloc) begin
            mem_wr.en         = 1'b1;
            mem_wr.addr       = g_r;
            mem_wr.data.size  = sz;
            mem_wr.data.alloc = 1'b0;
            res_status_nxt    = ffha_pkg::STATUS_OK;
          end else begin
            res_status_nxt = ffha_pkg::STATUS_BAD_FREE;
          end
          state_nxt = ST_FIN;
        end else if (bad || n_last || nsum > {1'b0, target_r}) begin
          res_status_nxt = ffha_pkg::STATUS_BAD_FREE;
          state_nxt      = ST_FIN;
        end else begin
          g_nxt       = nxt_g;
          mem_rd.en   = 1'b1;
          mem_rd.addr = nxt_g;
          state_nxt   = ST_R_LD;
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_BOOT_HDR;
      heap_end_r <= ffha_pkg::GRAN_W'(ffha_pkg::HEAP_GRANULES - 1);
      retried_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      heap_end_r <= heap_end_nxt;
      retried_r  <= retried_nxt;
    end
    mode_r        <= mode_nxt;
    need_r        <= need_nxt;
    target_r      <= target_nxt;
    g_r           <= g_nxt;
    n_r           <= n_nxt;
    h_r           <= h_nxt;
    res_payload_r <= res_payload_nxt;
    res_status_r  <= res_status_nxt;
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign res.valid   = (state_r == ST_FIN);
  assign res.payload = res_payload_r;
  assign res.status  = res_status_r;

endmodule

`default_nettype wire

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator over an implicit list of 8-byte granule blocks:
// one 1024-entry header RAM with a single registered read port, walked by a
// sequencer; a result register decouples the output channel. After reset the
// heap is formatted (first header, then sentinel) before the first beat is
// taken. One item is worked on at a time: init writes the first header and
// the sentinel (no write when the heap would not fit), free reads and checks
// each block header passed, coalesce reads each header and writes back each
// merge, and allocate reads each header on the first-fit pass (with one more
// write for a split), plus a coalesce pass and a second fit pass when nothing
// fits first time; the result is then handed over. The header RAM gives one
// header per read. Depends on ffha_pkg, ffha_mem and ffha_walker.
`default_nettype none

module first_fit_heap_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ffha_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [ffha_pkg::BYTES_W-1:0]    in_request_bytes,
  input  wire logic [ffha_pkg::GRAN_W-1:0]     in_block_granule,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ffha_pkg::GRAN_W-1:0]          out_payload_granule,
  output logic [ffha_pkg::STATUS_W-1:0]        out_status
);

  ffha_pkg::mem_wr_t  mem_wr;
  ffha_pkg::mem_rd_t  mem_rd;
  ffha_pkg::header_t  mem_rd_data;
  ffha_pkg::result_t  res;
  logic               res_ready;

  logic                          out_valid_r;
  logic [ffha_pkg::GRAN_W-1:0]   out_payload_r;
  logic [ffha_pkg::STATUS_W-1:0] out_status_r;

  ffha_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

  ffha_walker u_walker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_request_bytes (in_request_bytes),
    .in_block_granule (in_block_granule),
    .mem_wr           (mem_wr),
    .mem_rd           (mem_rd),
    .mem_rd_data      (mem_rd_data),
    .res              (res),
    .res_ready        (res_ready)
  );

  // result register takes a new beat when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
    if (res_ready && res.valid) begin
      out_payload_r <= res.payload;
      out_status_r  <= res.status;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_payload_granule = out_payload_r;
  assign out_status          = out_status_r;

  // the sequencer never offers a result while it is open for a new item
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && res.valid))
    else $error("input ready while a result is pending");

  // an accepted item closes the input until its result is handed over
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

  // only a successful allocate carries a nonzero payload
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ffha_pkg::STATUS_OK) |-> (out_payload_granule == '0))
    else $error("nonzero payload with error status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ffha_pkg::STATUS_OK ||
                   out_status == ffha_pkg::STATUS_NO_SPACE ||
                   out_status == ffha_pkg::STATUS_BAD_FREE))
    else $error("undefined status code");

endmodule

`default_nettype wire

// ===== tb/ffha_heap_checker.sv =====
// Checker for first_fit_heap_allocator: keeps its own copy of the heap headers,
// predicts one reply per request beat and compares every reply beat in order.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_heap_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [ffha_pkg::MODE_W-1:0]     in_mode,
  input  wire logic [ffha_pkg::BYTES_W-1:0]    in_request_bytes,
  input  wire logic [ffha_pkg::GRAN_W-1:0]     in_block_granule,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [ffha_pkg::GRAN_W-1:0]     out_payload_granule,
  input  wire logic [ffha_pkg::STATUS_W-1:0]   out_status,
  output int                                   fail_count,
  output int                                   replies_due
);
  import ffha_pkg::*;

  typedef struct packed {
    logic [GRAN_W-1:0]   payload;
    logic [STATUS_W-1:0] status;
  } reply_t;

  header_t hdr_mem [HEAP_GRANULES];
  int      sentinel_at;
  reply_t  awaited_replies[$];

  function automatic int round_to_granules(input logic [BYTES_W-1:0] bytes);
    return (int'(bytes) + 3) / 8 + 1;
  endfunction

  // Walks stop at a zero-size header or at a block running past the sentinel.
  function automatic bit fit_first(input int need, output int at);
    int g, sz;
    at = 0;
    g = 0;
    while (g < sentinel_at) begin
      sz = hdr_mem[g].size;
      if (sz == 0 || sz > sentinel_at - g) return 1'b0;
      if (!hdr_mem[g].alloc && sz >= need) begin
        hdr_mem[g] = '{size: SIZE_W'(need), alloc: 1'b1};
        if (sz > need) hdr_mem[g + need] = '{size: SIZE_W'(sz - need), alloc: 1'b0};
        at = g;
        return 1'b1;
      end
      g += sz;
    end
    return 1'b0;
  endfunction

  function automatic void merge_runs();
    int g, sz, nxt, nsz;
    g = 0;
    while (g < sentinel_at) begin
      sz = hdr_mem[g].size;
      if (sz == 0 || sz > sentinel_at - g) return;
      nxt = g + sz;
      if (nxt < sentinel_at && !hdr_mem[g].alloc && !hdr_mem[nxt].alloc) begin
        nsz = hdr_mem[nxt].size;
        if (nsz == 0 || nsz > sentinel_at - nxt) return;
        // stay on g: the grown block may swallow the following one as well
        hdr_mem[g].size = SIZE_W'(sz + nsz);
      end else begin
        g = nxt;
      end
    end
  endfunction

  function automatic reply_t predict_heap(input logic [MODE_W-1:0]  mode,
                                          input logic [BYTES_W-1:0] bytes,
                                          input logic [GRAN_W-1:0]  gran);
    reply_t r;
    int g, sz, at;
    r = '{payload: '0, status: STATUS_OK};
    case (mode)
      MODE_INIT: begin
        sz = round_to_granules(bytes);
        if (sz > HEAP_GRANULES - 1) begin
          r.status = STATUS_NO_SPACE;
        end else begin
          sentinel_at = sz;
          hdr_mem[0]  = '{size: SIZE_W'(sz), alloc: 1'b0};
          hdr_mem[sz] = '{size: '0, alloc: 1'b1};
        end
      end
      MODE_ALLOC: begin
        sz = round_to_granules(bytes);
        if (!fit_first(sz, at)) begin
          merge_runs();
          if (!fit_first(sz, at)) r.status = STATUS_NO_SPACE;
        end
        if (r.status == STATUS_OK) r.payload = GRAN_W'(at);
      end
      MODE_FREE: begin
        // only an allocated block start reached along the list may be freed
        r.status = STATUS_BAD_FREE;
        g = 0;
        while (g < sentinel_at && g <= int'(gran)) begin
          if (g == int'(gran)) begin
            if (hdr_mem[g].alloc) begin
              hdr_mem[g].alloc = 1'b0;
              r.status = STATUS_OK;
            end
            break;
          end
          sz = hdr_mem[g].size;
          if (sz == 0 || sz > sentinel_at - g) break;
          g += sz;
        end
      end
      default: merge_runs();
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < HEAP_GRANULES; i++) hdr_mem[i] = '0;
      sentinel_at = HEAP_GRANULES - 1;
      hdr_mem[0] = '{size: SIZE_W'(HEAP_GRANULES - 1), alloc: 1'b0};
      hdr_mem[HEAP_GRANULES - 1] = '{size: '0, alloc: 1'b1};
      awaited_replies.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $error("reply beat with no request outstanding: payload_granule %0d, status %0d",
                 out_payload_granule, out_status);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_payload_granule !== want.payload) begin
            $error("payload_granule: expected %0d, actual %0d", want.payload,
                   out_payload_granule);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_replies.push_back(predict_heap(in_mode, in_request_bytes, in_block_granule));
    end
    replies_due <= awaited_replies.size();
  end

endmodule

// ===== tb/tb_first_fit_heap_allocator.sv =====
// Top of the first_fit_heap_allocator testbench: clock, reset, request and
// reply handshakes with random idling, verdict. Depends on ffha_pkg and ffha_heap_checker.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int STALL_LIMIT = 60000;
  localparam int ITEM_COUNT  = 1000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode = MODE_INIT;
  logic [BYTES_W-1:0]  in_request_bytes = '0;
  logic [GRAN_W-1:0]   in_block_granule = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [GRAN_W-1:0]   out_payload_granule;
  logic [STATUS_W-1:0] out_status;

  int                  fail_count;
  int                  replies_due;
  int                  items_sent = 0;
  int                  quiet_cycles = 0;
  bit                  steady = 1'b0;
  logic [MODE_W-1:0]   modes_in_flight[$];
  logic [GRAN_W-1:0]   live_blocks[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  first_fit_heap_allocator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_request_bytes    (in_request_bytes),
    .in_block_granule    (in_block_granule),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_granule (out_payload_granule),
    .out_status          (out_status)
  );

  ffha_heap_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_request_bytes    (in_request_bytes),
    .in_block_granule    (in_block_granule),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_granule (out_payload_granule),
    .out_status          (out_status),
    .fail_count          (fail_count),
    .replies_due         (replies_due)
  );

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 22);

  // Remember granules handed out so that most frees name a live block.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && modes_in_flight.size() != 0) begin
      if (modes_in_flight.pop_front() == MODE_ALLOC && out_status == STATUS_OK)
        live_blocks.push_back(out_payload_granule);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(input logic [MODE_W-1:0]  mode,
                              input logic [BYTES_W-1:0] bytes,
                              input logic [GRAN_W-1:0]  gran);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 22) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_request_bytes <= bytes;
    in_block_granule <= gran;
    if (mode == MODE_INIT) live_blocks.delete();
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    modes_in_flight.push_back(mode);
    items_sent++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due != 0);
  endtask

  initial begin
    int                 n_ops, pick, slot;
    logic [BYTES_W-1:0] heap_bytes;
    logic [GRAN_W-1:0]  target;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // heap as formatted by reset: 1023 free granules
    send_request(MODE_ALLOC, 13'd0, 10'd0);
    send_request(MODE_ALLOC, 13'd8191, 10'd1023);   // larger than the whole heap
    send_request(MODE_FREE, 13'd0, 10'd0);
    send_request(MODE_FREE, 13'd0, 10'd0);          // double free
    send_request(MODE_FREE, 13'd8191, 10'd1023);    // sentinel
    send_request(MODE_FREE, 13'd0, 10'd1);          // start of a free block
    send_request(MODE_COAL, 13'd0, 10'd0);
    send_request(MODE_INIT, 13'd8181, 10'd0);       // one granule too many
    send_request(MODE_INIT, 13'd8191, 10'd0);
    send_request(MODE_INIT, 13'd8180, 10'd0);       // largest heap that fits
    // one-granule heap
    send_request(MODE_INIT, 13'd0, 10'd0);
    send_request(MODE_ALLOC, 13'd0, 10'd0);
    send_request(MODE_ALLOC, 13'd0, 10'd0);
    send_request(MODE_FREE, 13'd0, 10'd1);
    // seven granules: fill, free two neighbors, then a fit only after merging
    send_request(MODE_INIT, 13'd45, 10'd0);
    send_request(MODE_ALLOC, 13'd4, 10'd0);
    send_request(MODE_ALLOC, 13'd5, 10'd0);
    send_request(MODE_ALLOC, 13'd13, 10'd0);
    send_request(MODE_FREE, 13'd0, 10'd1);
    send_request(MODE_FREE, 13'd0, 10'd3);
    send_request(MODE_ALLOC, 13'd40, 10'd0);
    send_request(MODE_ALLOC, 13'd0, 10'd0);
    send_request(MODE_FREE, 13'd0, 10'd5);          // inside a block
    drain_replies();

    // sessions: init a heap, then a run of alloc/free traffic with some noise
    while (items_sent < ITEM_COUNT) begin
      steady = (items_sent >= 450 && items_sent < 650);
      if ($urandom_range(2) == 0) drain_replies();
      if ($urandom_range(7) == 0)
        heap_bytes = 13'($urandom_range(8191));
      else
        heap_bytes = 13'($urandom_range(2047));
      send_request(MODE_INIT, heap_bytes, 10'($urandom));
      n_ops = $urandom_range(40, 10);
      repeat (n_ops) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_request(MODE_ALLOC,
                       ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(120)),
                       10'($urandom));
        end else if (pick < 80) begin
          if (live_blocks.size() != 0 && $urandom_range(99) < 85) begin
            slot   = $urandom_range(live_blocks.size() - 1);
            target = live_blocks[slot];
            live_blocks.delete(slot);
          end else begin
            target = 10'($urandom);
          end
          send_request(MODE_FREE, 13'($urandom), target);
        end else if (pick < 88) begin
          send_request(MODE_COAL, 13'($urandom), 10'($urandom));
        end else begin
          send_request(2'($urandom), 13'($urandom), 10'($urandom));
        end
      end
    end
    steady = 1'b0;

    drain_replies();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
